[design/sac_pkg.sv]
package sac_pkg;

    // Fixed field widths of the stream and configuration ports.
    localparam int IN_ADDR_W  = 32;
    localparam int CNT_W      = 32;
    localparam int OUT_WAY_W  = 3;
    localparam int S_TDATA_W  = 32;
    localparam int M_TDATA_W  = 104;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Raw set index width: set_bits is three bits wide.
    localparam int SET_RAW_W = 7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_USED    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POLICY       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HIT_TIME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MISS_PENALTY = 3'd5;

    // Replacement policy codes.
    localparam logic POLICY_LRU = 1'b0;
    localparam logic POLICY_LFU = 1'b1;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH
    } sac_state_t;

    // Outcome of the way scan of one set.
    typedef struct packed {
        logic found;
        logic hit;
    } sac_lookup_t;

endpackage

[design/sac_mem.sv]
module sac_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int WIDTH  = 776
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/sac_lookup.sv]
module sac_lookup #(
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32,
    parameter int WAY_W      = 3,
    parameter int NW_W       = 4
) (
    input  logic [MAX_WAYS-1:0]                 line_valid,
    input  logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] line_tag,
    input  logic [ADDR_WIDTH-1:0]               line_addr,
    input  logic [NW_W-1:0]                     nways,
    output sac_pkg::sac_lookup_t                result,
    output logic [WAY_W-1:0]                    way
);

    logic [MAX_WAYS-1:0] way_fill;
    logic [MAX_WAYS-1:0] way_hit;
    logic [MAX_WAYS-1:0] way_decides;

    // Per-way classification: an empty way takes a fill, a matching way hits.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_fill[w] = (w < 32'(nways)) && !line_valid[w];
            way_hit[w]  = (w < 32'(nways)) && line_valid[w] && (line_tag[w] == line_addr);
        end
        way_decides = way_fill | way_hit;
    end

    // The lowest-numbered deciding way wins.
    always_comb begin
        way        = '0;
        result.hit = 1'b0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (way_decides[w]) begin
                way        = WAY_W'(w);
                result.hit = way_hit[w];
            end
        end
        result.found = |way_decides;
    end

endmodule

[design/set_assoc_cache_lru_lfu_top.sv]
// Set-associative cache tag model with LRU or LFU replacement. Each address beat on the
// s_ side yields one result beat on the m_ side with the hit flag, the way used and the
// running hit, miss and charged-cycle totals. All ways of a set live in one row of a
// single-port-read, single-port-write row memory with a registered read, so an access is a
// read-modify-write of its row: a hit or a fill is committed from the lookup state, and
// a miss in a full set goes on to a search state where the victim is found by a scan over
// the used ways, one way per cycle. After reset a clearing pass writes every row once while
// s_tready stays low; configuration writes are taken throughout. The result register lets
// the next address be accepted while a result waits.
module set_assoc_cache_lru_lfu_top #(
    parameter int MAX_SETS   = 64,
    parameter int MAX_WAYS   = 8,
    parameter int ADDR_WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration write port.
    input  logic                               cfg_wr_en,
    input  logic [sac_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  logic [sac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Address input.
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [sac_pkg::S_TDATA_W-1:0]      s_tdata,   // [31:0] address
    // Result output.
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] hit, [3:1] way, [35:4] hit_total, [67:36] miss_total,
    // [99:68] cycle_total, [103:100] zero
    output logic [sac_pkg::M_TDATA_W-1:0]      m_tdata
);

    localparam int SET_W   = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int NW_W    = $clog2(MAX_WAYS + 1);
    localparam int CW      = sac_pkg::CNT_W;
    localparam int TAG_LSB = MAX_WAYS;
    localparam int CNT_LSB = MAX_WAYS * (1 + ADDR_WIDTH);
    localparam int STP_LSB = MAX_WAYS * (1 + ADDR_WIDTH + CW);
    localparam int ROW_W   = MAX_WAYS * (1 + ADDR_WIDTH + 2 * CW);
    localparam int RAW_N   = 2 ** sac_pkg::SET_RAW_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    // Fold of a raw set index onto the sets that exist.
    function automatic logic [RAW_N*SET_W-1:0] build_set_fold();
        logic [RAW_N*SET_W-1:0] tab;
        tab = '0;
        for (int i = 0; i < RAW_N; i++) begin
            tab[i*SET_W +: SET_W] = SET_W'(i % MAX_SETS);
        end
        return tab;
    endfunction

    localparam logic [RAW_N*SET_W-1:0] SET_FOLD = build_set_fold();

    // Configuration registers.
    logic [3:0]  offset_bits_reg;
    logic [2:0]  set_bits_reg;
    logic [3:0]  ways_used_reg;
    logic        policy_reg;
    logic [15:0] hit_time_reg;
    logic [15:0] miss_penalty_reg;

    // Control state.
    sac_pkg::sac_state_t state_reg, state_next;
    logic [SET_W-1:0]    clr_idx_reg;
    logic [NW_W-1:0]     idx_reg;
    logic                m_valid_reg, m_valid_next;

    // Per-access payload.
    logic [ADDR_WIDTH-1:0] line_addr_reg;
    logic [SET_W-1:0]      set_reg;
    logic [NW_W-1:0]       nways_reg;
    logic                  item_policy_reg;
    logic [16:0]           miss_charge_reg;
    logic [WAY_W-1:0]      vict_reg;
    logic [CW-1:0]         best_reg;
    logic [CW-1:0]         hits_reg, misses_reg, cycles_reg;
    logic [sac_pkg::M_TDATA_W-1:0] m_data_reg;

    // Handshake and sequencing controls.
    logic accept, out_free, clr_last, search_step, commit;

    // Address split of the incoming beat.
    logic [ADDR_WIDTH-1:0]         addr_in, line_in, addr_sh;
    logic [sac_pkg::SET_RAW_W-1:0] set_raw;
    logic [SET_W-1:0]              set_in;
    logic [NW_W-1:0]               nways_in;

    // Row memory ports.
    logic             mem_wr_en;
    logic [SET_W-1:0] mem_wr_addr;
    logic [ROW_W-1:0] mem_wr_data, rd_row;

    // Unpacked row.
    logic [MAX_WAYS-1:0]                 rd_valid;
    logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] rd_tag;
    logic [MAX_WAYS-1:0][CW-1:0]         rd_cnt, rd_stp;

    sac_pkg::sac_lookup_t lk;
    logic [WAY_W-1:0]     lk_way;
    logic [WAY_W-1:0]     commit_way;
    logic                 commit_hit;
    logic [CW-1:0]        key_first, key_step;
    logic [CW-1:0]        hits_next, misses_next, cycles_next;
    logic [CW:0]          cycle_sum;
    logic [16:0]          charge;

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_bits_reg  <= 4'd0;
            set_bits_reg     <= 3'd0;
            ways_used_reg    <= 4'd8;
            policy_reg       <= sac_pkg::POLICY_LRU;
            hit_time_reg     <= 16'd1;
            miss_penalty_reg <= 16'd0;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                sac_pkg::CFG_OFFSET_BITS:  offset_bits_reg  <= cfg_wdata[3:0];
                sac_pkg::CFG_SET_BITS:     set_bits_reg     <= cfg_wdata[2:0];
                sac_pkg::CFG_WAYS_USED:    ways_used_reg    <= cfg_wdata[3:0];
                sac_pkg::CFG_POLICY:       policy_reg       <= cfg_wdata[0];
                sac_pkg::CFG_HIT_TIME:     hit_time_reg     <= cfg_wdata;
                sac_pkg::CFG_MISS_PENALTY: miss_penalty_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Split the address into line address and set index.
    always_comb begin
        addr_in = ADDR_WIDTH'(s_tdata);
        line_in = addr_in & ({ADDR_WIDTH{1'b1}} << offset_bits_reg);
        addr_sh = addr_in >> offset_bits_reg;
        set_raw = addr_sh[sac_pkg::SET_RAW_W-1:0]
                & ~({sac_pkg::SET_RAW_W{1'b1}} << set_bits_reg);
        set_in  = SET_FOLD[32'(set_raw)*SET_W +: SET_W];
    end

    // Number of ways in use, clamped to one and to the physical count.
    always_comb begin
        if (ways_used_reg == 4'd0) begin
            nways_in = NW_W'(1);
        end else if (32'(ways_used_reg) > MAX_WAYS) begin
            nways_in = NW_W'(MAX_WAYS);
        end else begin
            nways_in = NW_W'(ways_used_reg);
        end
    end

    // Unpack the row read from memory.
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            rd_valid[w] = rd_row[w];
            rd_tag[w]   = rd_row[TAG_LSB + w*ADDR_WIDTH +: ADDR_WIDTH];
            rd_cnt[w]   = rd_row[CNT_LSB + w*CW +: CW];
            rd_stp[w]   = rd_row[STP_LSB + w*CW +: CW];
        end
    end

    sac_lookup #(
        .MAX_WAYS   (MAX_WAYS),
        .ADDR_WIDTH (ADDR_WIDTH),
        .WAY_W      (WAY_W),
        .NW_W       (NW_W)
    ) u_lookup (
        .line_valid (rd_valid),
        .line_tag   (rd_tag),
        .line_addr  (line_addr_reg),
        .nways      (nways_reg),
        .result     (lk),
        .way        (lk_way)
    );

    // Replacement keys: use count under LFU, last-use stamp under LRU.
    always_comb begin
        if (item_policy_reg == sac_pkg::POLICY_LFU) begin
            key_first = rd_cnt[0];
            key_step  = rd_cnt[idx_reg[WAY_W-1:0]];
        end else begin
            key_first = rd_stp[0];
            key_step  = rd_stp[idx_reg[WAY_W-1:0]];
        end
    end

    assign out_free    = !m_valid_reg || m_tready;
    assign clr_last    = (clr_idx_reg == SET_W'(MAX_SETS - 1));
    assign search_step = (idx_reg < nways_reg);

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            sac_pkg::ST_CLEAR: begin
                if (clr_last) begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = sac_pkg::ST_EVAL;
                end
            end
            sac_pkg::ST_EVAL: begin
                if (!lk.found) begin
                    state_next = sac_pkg::ST_SEARCH;
                end else if (out_free) begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            sac_pkg::ST_SEARCH: begin
                if (!search_step && out_free) begin
                    state_next = sac_pkg::ST_IDLE;
                end
            end
            default: state_next = sac_pkg::ST_CLEAR;
        endcase
    end

    // State outputs.
    always_comb begin
        s_tready   = 1'b0;
        commit     = 1'b0;
        commit_hit = 1'b0;
        commit_way = vict_reg;
        unique case (state_reg)
            sac_pkg::ST_CLEAR: ;
            sac_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            sac_pkg::ST_EVAL: begin
                commit     = lk.found && out_free;
                commit_hit = lk.hit;
                commit_way = lk_way;
            end
            sac_pkg::ST_SEARCH: begin
                commit = !search_step && out_free;
            end
            default: ;
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // Build the write-back row: the chosen way is updated, the others kept.
    always_comb begin
        logic [MAX_WAYS-1:0]                 nv;
        logic [MAX_WAYS-1:0][ADDR_WIDTH-1:0] nt;
        logic [MAX_WAYS-1:0][CW-1:0]         nc, ns;
        nv = rd_valid;
        nt = rd_tag;
        nc = rd_cnt;
        ns = rd_stp;
        ns[commit_way] = cycles_reg;
        if (state_reg == sac_pkg::ST_SEARCH) begin
            nt[commit_way] = line_addr_reg;
            nc[commit_way] = CW'(1);
        end else begin
            nv[commit_way] = 1'b1;
            nt[commit_way] = line_addr_reg;
            nc[commit_way] = (rd_cnt[commit_way] == CNT_MAX) ? CNT_MAX
                                                             : rd_cnt[commit_way] + CW'(1);
        end
        mem_wr_data = '0;
        if (state_reg != sac_pkg::ST_CLEAR) begin
            for (int w = 0; w < MAX_WAYS; w++) begin
                mem_wr_data[w]                                    = nv[w];
                mem_wr_data[TAG_LSB + w*ADDR_WIDTH +: ADDR_WIDTH] = nt[w];
                mem_wr_data[CNT_LSB + w*CW +: CW]                 = nc[w];
                mem_wr_data[STP_LSB + w*CW +: CW]                 = ns[w];
            end
        end
    end

    assign mem_wr_en   = commit || (state_reg == sac_pkg::ST_CLEAR);
    assign mem_wr_addr = (state_reg == sac_pkg::ST_CLEAR) ? clr_idx_reg : set_reg;

    sac_mem #(
        .DEPTH  (MAX_SETS),
        .ADDR_W (SET_W),
        .WIDTH  (ROW_W)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (accept),
        .rd_addr (set_in),
        .rd_data (rd_row)
    );

    // Saturating totals for the committed access.
    always_comb begin
        charge      = commit_hit ? {1'b0, hit_time_reg} : miss_charge_reg;
        cycle_sum   = {1'b0, cycles_reg} + (CW + 1)'(charge);
        cycles_next = cycle_sum[CW] ? CNT_MAX : cycle_sum[CW-1:0];
        hits_next   = hits_reg;
        misses_next = misses_reg;
        if (commit_hit) begin
            hits_next = (hits_reg == CNT_MAX) ? CNT_MAX : hits_reg + CW'(1);
        end else begin
            misses_next = (misses_reg == CNT_MAX) ? CNT_MAX : misses_reg + CW'(1);
        end
    end

    assign m_valid_next = commit ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sac_pkg::ST_CLEAR;
            clr_idx_reg <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            hits_reg    <= '0;
            misses_reg  <= '0;
            cycles_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (state_reg == sac_pkg::ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + SET_W'(1);
            end
            if (state_reg == sac_pkg::ST_EVAL) begin
                idx_reg <= NW_W'(1);
            end else if (state_reg == sac_pkg::ST_SEARCH && search_step) begin
                idx_reg <= idx_reg + NW_W'(1);
            end
            if (commit) begin
                hits_reg   <= hits_next;
                misses_reg <= misses_next;
                cycles_reg <= cycles_next;
            end
        end
    end

    // Payload registers: access capture, victim scan and result beat.
    always_ff @(posedge aclk) begin
        if (accept) begin
            line_addr_reg   <= line_in;
            set_reg         <= set_in;
            nways_reg       <= nways_in;
            item_policy_reg <= policy_reg;
            miss_charge_reg <= {1'b0, hit_time_reg} + {1'b0, miss_penalty_reg};
        end
        if (state_reg == sac_pkg::ST_EVAL) begin
            vict_reg <= '0;
            best_reg <= key_first;
        end else if (state_reg == sac_pkg::ST_SEARCH && search_step) begin
            if (key_step < best_reg) begin
                vict_reg <= idx_reg[WAY_W-1:0];
                best_reg <= key_step;
            end
        end
        if (commit) begin
            m_data_reg <= {4'b0000, cycles_next, misses_next, hits_next,
                           sac_pkg::OUT_WAY_W'(commit_way), commit_hit};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // An accepted address always moves on to the lookup of its set.
    a_accept_to_eval: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == sac_pkg::ST_EVAL)
        else $error("accepted beat did not enter lookup");

    // A result is never written over one that is still waiting.
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten");

    // The chosen way is always one of the ways in use.
    a_way_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        commit |-> commit_way < nways_reg)
        else $error("committed way outside ways in use");

    // A row read never coincides with a write-back of the row memory.
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(accept && mem_wr_en))
        else $error("row read overlaps a row write");

endmodule
